@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/msfs_pkg.sv @@
// Shared types, widths and codes of the Maxwellian source flux sum unit.
// Depends on nothing; used by msfs_mul, msfs_div and the top level of the block.
package msfs_pkg;

   localparam int MAX_SOURCES = 8;
   localparam int SRC_IDX_W   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
   localparam int RAM_AW      = SRC_IDX_W + 1;
   localparam int RAM_DEPTH   = 2 ** RAM_AW;
   localparam int PEAK_W      = 32;
   localparam int MAG_W       = 48;
   localparam int ENTRY_W     = PEAK_W + MAG_W;

   localparam int DVD_W  = 96;
   localparam int QUO_W  = 63;
   localparam int DSR_W  = 32;
   localparam int STEP_W = 7;
   localparam int OP_W   = 64;
   localparam int PROD_W = 128;

   localparam int TAYLOR_TERMS = 20;

   localparam logic [1:0] REQ_EVAL     = 2'd0;
   localparam logic [1:0] REQ_LOAD_ION = 2'd1;
   localparam logic [1:0] REQ_LOAD_MAG = 2'd2;
   localparam logic [1:0] REQ_CLEAR    = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_BAD_PEAK  = 3'd2;
   localparam logic [2:0] ST_BAD_MAG   = 3'd3;
   localparam logic [2:0] ST_BAD_PARTS = 3'd4;

   localparam logic [1:0] CSR_ION_BOUNDARY = 2'd0;
   localparam logic [1:0] CSR_MAG_BOUNDARY = 2'd1;
   localparam logic [1:0] CSR_ION_SCALE    = 2'd2;
   localparam logic [1:0] CSR_MAG_SCALE    = 2'd3;

   localparam logic [QUO_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [DSR_W-1:0]  divisor;
      logic [DVD_W-1:0]  dividend;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic            start;
      logic [OP_W-1:0] a;
      logic [OP_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   // exp(-1) in Q.32, built from the same truncated alternating series as the datapath.
   function automatic logic [32:0] exp_neg1_q32();
      logic [35:0] t;
      logic [35:0] pos;
      logic [35:0] neg;
      t   = 36'h1_0000_0000;
      pos = '0;
      neg = '0;
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
         if ((k & 1) == 1) begin
            neg = neg + t;
         end else begin
            pos = pos + t;
         end
         t = t / 36'(k + 1);
      end
      return 33'(pos - neg);
   endfunction

   localparam logic [32:0] EXP_NEG1 = exp_neg1_q32();

endpackage

@@ rtl/msfs_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; holds the source tables of the block.
module msfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/msfs_mul.sv @@
// Sequential 64x64 multiplier built from four registered 32x32 partial products.
// Depends on msfs_pkg for the command and response structs.
module msfs_mul import msfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);

   logic              run_ff, run_in;
   logic [1:0]        step_ff, step_in;
   logic              pv_ff, pv_in;
   logic              last_ff, last_in;
   logic              done_ff, done_in;
   logic [OP_W-1:0]   a_ff, b_ff;
   logic [63:0]       pp_ff, pp_in;
   logic [1:0]        shift_ff, shift_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [31:0]       a_half, b_half;
   logic [PROD_W-1:0] addend;

   always_comb begin
      a_half   = step_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half   = step_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp_in    = {32'd0, a_half} * {32'd0, b_half};
      shift_in = {1'b0, step_ff[0]} + {1'b0, step_ff[1]};
      case (shift_ff)
         2'd0:    addend = {64'd0, pp_ff};
         2'd1:    addend = {32'd0, pp_ff, 32'd0};
         default: addend = {pp_ff, 64'd0};
      endcase
      run_in  = run_ff;
      step_in = step_ff;
      if (cmd.start) begin
         run_in  = 1'b1;
         step_in = 2'd0;
      end else if (run_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            run_in = 1'b0;
         end
      end
      pv_in   = run_ff && !cmd.start;
      last_in = run_ff && (step_ff == 2'd3);
      done_in = pv_ff && last_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (pv_ff) begin
         acc_in = acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= 2'd0;
         pv_ff   <= 1'b0;
         last_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         pv_ff   <= pv_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_ff <= cmd.a;
         b_ff <= cmd.b;
      end
      pp_ff    <= pp_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

@@ rtl/msfs_div.sv @@
// Restoring divider, one quotient bit per cycle, left-aligned dividend, saturating quotient.
// Depends on msfs_pkg for the command and response structs.
module msfs_div import msfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic              run_ff, run_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DSR_W-1:0]  dsr_ff;
   logic [DSR_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  q_ff, q_in;
   logic              sat_ff, sat_in;
   logic [DSR_W:0]    trial;
   logic [DSR_W:0]    diff;
   logic              ge;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      ge     = trial >= {1'b0, dsr_ff};
      rem_in = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      q_in   = {q_ff[QUO_W-2:0], ge};
      sat_in = sat_ff || (ge && (cnt_ff > STEP_W'(QUO_W)));
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (cmd.start) begin
         run_in = 1'b1;
         cnt_in = cmd.steps;
      end else if (run_ff) begin
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            run_in = 1'b0;
         end
      end
      done_in = run_ff && !cmd.start && (cnt_ff == STEP_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dvd_ff <= cmd.dividend;
         dsr_ff <= cmd.divisor;
         rem_ff <= '0;
         q_ff   <= '0;
         sat_ff <= 1'b0;
      end else if (run_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= rem_in;
         q_ff   <= q_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = sat_ff ? COUNT_MAX : q_ff;

endmodule

@@ rtl/maxwellian_source_flux_sum_unit.sv @@
// Maxwellian source flux sum unit: two source tables in one RAM and a sequencer that
// evaluates the summed Maxwellian count of one particle. Uses msfs_pkg, msfs_ram,
// msfs_mul and msfs_div.
//
// Requests arrive on req_valid/req_ready and each gives exactly one response on
// rsp_valid/rsp_ready. Requests are handled one at a time; req_ready is high only
// while the sequencer is idle. A finished response sits in the output register,
// so the next request is taken while a stalled receiver still holds the previous one.
// A clear or a rejected load goes straight to the output state; an accepted load waits
// on the 48-step magnitude divide. An evaluate runs, for each live gated-in entry,
// a 57-step ratio divide and, unless the ratio is too large, up to 19 series steps of
// a multiply and a 35-step divide, up to 61 further multiplies for large ratios, three
// multiplies and a 96-step final divide. All of it runs through one shared bit-serial
// divider and one shared 4-pass multiplier.
// Configuration writes on csr_wr_en take effect at once and are meant for idle times.
// Synchronous reset empties both tables, restores the default scales and drops any
// pending response; table entries are not cleared and are read only once written.
module maxwellian_source_flux_sum_unit import msfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [31:0]        req_energy,
   input  logic [31:0]        req_position,
   input  logic signed [31:0] req_peak_energy,
   input  logic signed [47:0] req_magnitude,
   input  logic signed [15:0] req_parts_at_energy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [62:0]        rsp_count,
   output logic [2:0]         rsp_status,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LDIV = 4'd1;
   localparam logic [3:0] S_NEXT = 4'd2;
   localparam logic [3:0] S_READ = 4'd3;
   localparam logic [3:0] S_RDIV = 4'd4;
   localparam logic [3:0] S_TADD = 4'd5;
   localparam logic [3:0] S_TMUL = 4'd6;
   localparam logic [3:0] S_TDIV = 4'd7;
   localparam logic [3:0] S_TFIN = 4'd8;
   localparam logic [3:0] S_GCHK = 4'd9;
   localparam logic [3:0] S_GMUL = 4'd10;
   localparam logic [3:0] S_AMUL = 4'd11;
   localparam logic [3:0] S_CMUL = 4'd12;
   localparam logic [3:0] S_PMUL = 4'd13;
   localparam logic [3:0] S_FDIV = 4'd14;
   localparam logic [3:0] S_OUT  = 4'd15;

   localparam logic [29:0] R_TWO   = 30'h200_0000;
   localparam logic [34:0] T_ONE   = 35'h1_0000_0000;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] ion_cnt_ff, ion_cnt_in, mag_cnt_ff, mag_cnt_in;
   logic [31:0]      ion_bnd_ff, mag_bnd_ff;
   logic [23:0]      ion_scl_ff, mag_scl_ff;
   logic             tbl_ff, tbl_in;
   logic [CNT_W-1:0] ent_ff, ent_in;
   logic             ion_on_ff, ion_on_in, mag_on_ff, mag_on_in;
   logic [31:0]      energy_ff, energy_in;
   logic [31:0]      pk_ff, pk_in;
   logic [30:0]      peak_ff, peak_in;
   logic [47:0]      mag_ff, mag_in;
   logic [29:0]      r_ff, r_in;
   logic             down_ff, down_in;
   logic [29:0]      dd_ff, dd_in;
   logic [34:0]      t_ff, t_in;
   logic [35:0]      psum_ff, psum_in, nsum_ff, nsum_in;
   logic [4:0]       k_ff, k_in;
   logic [35:0]      g_ff, g_in;
   logic [5:0]       gcnt_ff, gcnt_in;
   logic [54:0]      a_ff, a_in;
   logic [39:0]      c_ff, c_in;
   logic [62:0]      sum_ff, sum_in;
   logic [2:0]       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [62:0]      rsp_count_ff, rsp_count_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;

   logic               ram_we;
   logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   div_cmd_type        div_cmd;
   div_rsp_type        div_rsp;
   mul_cmd_type        mul_cmd;
   mul_rsp_type        mul_rsp;

   logic [41:0]      pos_x1000, ion_lim, mag_lim;
   logic [2:0]       load_status;
   logic [CNT_W-1:0] load_cnt, cur_cnt;
   logic             cur_on;
   logic [29:0]      tay_d;
   logic [23:0]      cur_scale;
   logic [63:0]      sum_wide;
   logic             accept;

   msfs_ram #(.WIDTH(ENTRY_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   msfs_div u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .rsp(div_rsp));
   msfs_mul u_mul (.clock(clock), .reset(reset), .cmd(mul_cmd), .rsp(mul_rsp));

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign ram_raddr = {tbl_ff, ent_ff[SRC_IDX_W-1:0]};

   always_comb begin
      pos_x1000 = {10'd0, req_position} * 42'd1000;
      ion_lim   = {10'd0, ion_bnd_ff} * 42'd1001;
      mag_lim   = {10'd0, mag_bnd_ff} * 42'd999;
      load_cnt  = (req_type == REQ_LOAD_MAG) ? mag_cnt_ff : ion_cnt_ff;
      if (req_peak_energy == 32'sd0 || req_peak_energy[31]) begin
         load_status = ST_BAD_PEAK;
      end else if (req_magnitude == 48'sd0 || req_magnitude[47]) begin
         load_status = ST_BAD_MAG;
      end else if (req_parts_at_energy == 16'sd0 || req_parts_at_energy[15]) begin
         load_status = ST_BAD_PARTS;
      end else if (load_cnt == CNT_W'(MAX_SOURCES)) begin
         load_status = ST_FULL;
      end else begin
         load_status = ST_OK;
      end
      cur_cnt   = tbl_ff ? mag_cnt_ff : ion_cnt_ff;
      cur_on    = tbl_ff ? mag_on_ff : ion_on_ff;
      cur_scale = tbl_ff ? mag_scl_ff : ion_scl_ff;
      tay_d     = down_ff ? {6'd0, dd_ff[23:0]} : dd_ff;
      sum_wide  = {1'b0, sum_ff} + {1'b0, div_rsp.quot};
   end

   always_comb begin
      state_in   = state_ff;
      ion_cnt_in = ion_cnt_ff;
      mag_cnt_in = mag_cnt_ff;
      tbl_in     = tbl_ff;
      ent_in     = ent_ff;
      ion_on_in  = ion_on_ff;
      mag_on_in  = mag_on_ff;
      energy_in  = energy_ff;
      pk_in      = pk_ff;
      peak_in    = peak_ff;
      mag_in     = mag_ff;
      r_in       = r_ff;
      down_in    = down_ff;
      dd_in      = dd_ff;
      t_in       = t_ff;
      psum_in    = psum_ff;
      nsum_in    = nsum_ff;
      k_in       = k_ff;
      g_in       = g_ff;
      gcnt_in    = gcnt_ff;
      a_in       = a_ff;
      c_in       = c_ff;
      sum_in     = sum_ff;
      status_in  = status_ff;
      ram_we     = 1'b0;
      ram_waddr  = {tbl_ff, load_cnt[SRC_IDX_W-1:0]};
      ram_wdata  = {pk_ff, div_rsp.quot[47:0]};
      div_cmd    = '0;
      mul_cmd    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sum_in    = '0;
               status_in = ST_OK;
               case (req_type) inside
                  REQ_EVAL: begin
                     energy_in = req_energy;
                     ion_on_in = !(pos_x1000 > ion_lim);
                     mag_on_in = !(pos_x1000 < mag_lim);
                     tbl_in    = 1'b0;
                     ent_in    = '0;
                     state_in  = (req_energy == 32'd0) ? S_OUT : S_NEXT;
                  end
                  REQ_CLEAR: begin
                     ion_cnt_in = '0;
                     mag_cnt_in = '0;
                     state_in   = S_OUT;
                  end
                  REQ_LOAD_ION, REQ_LOAD_MAG: begin
                     status_in = load_status;
                     pk_in     = req_peak_energy;
                     tbl_in    = (req_type == REQ_LOAD_MAG);
                     if (load_status == ST_OK) begin
                        div_cmd.start    = 1'b1;
                        div_cmd.steps    = STEP_W'(48);
                        div_cmd.divisor  = {16'd0, req_parts_at_energy};
                        div_cmd.dividend = {req_magnitude, 48'd0};
                        state_in         = S_LDIV;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_LDIV: begin
            ram_waddr = {tbl_ff, cur_cnt[SRC_IDX_W-1:0]};
            if (div_rsp.done) begin
               ram_we = 1'b1;
               if (tbl_ff) begin
                  mag_cnt_in = mag_cnt_ff + CNT_W'(1);
               end else begin
                  ion_cnt_in = ion_cnt_ff + CNT_W'(1);
               end
               state_in = S_OUT;
            end
         end
         S_NEXT: begin
            if (cur_on && (ent_ff < cur_cnt)) begin
               state_in = S_READ;
            end else if (!tbl_ff) begin
               tbl_in = 1'b1;
               ent_in = '0;
            end else begin
               state_in = S_OUT;
            end
         end
         S_READ: begin
            peak_in          = ram_rdata[78:48];
            mag_in           = ram_rdata[47:0];
            div_cmd.start    = 1'b1;
            div_cmd.steps    = STEP_W'(57);
            div_cmd.divisor  = {1'b0, ram_rdata[78:48]};
            div_cmd.dividend = {energy_ff, 64'd0};
            state_in         = S_RDIV;
         end
         S_RDIV: begin
            if (div_rsp.done) begin
               if (|div_rsp.quot[62:30]) begin
                  ent_in   = ent_ff + CNT_W'(1);
                  state_in = S_NEXT;
               end else begin
                  r_in    = div_rsp.quot[29:0];
                  down_in = div_rsp.quot[29:0] > R_TWO;
                  dd_in   = (div_rsp.quot[29:0] > R_TWO) ? (div_rsp.quot[29:0] - R_TWO)
                                                        : (R_TWO - div_rsp.quot[29:0]);
                  t_in     = T_ONE;
                  psum_in  = '0;
                  nsum_in  = '0;
                  k_in     = '0;
                  state_in = S_TADD;
               end
            end
         end
         S_TADD: begin
            if (down_ff && k_ff[0]) begin
               nsum_in = nsum_ff + {1'b0, t_ff};
            end else begin
               psum_in = psum_ff + {1'b0, t_ff};
            end
            if (k_ff == 5'(TAYLOR_TERMS - 1) || t_ff == '0) begin
               state_in = S_TFIN;
            end else begin
               mul_cmd.start = 1'b1;
               mul_cmd.a     = {29'd0, t_ff};
               mul_cmd.b     = {34'd0, tay_d};
               state_in      = S_TMUL;
            end
         end
         S_TMUL: begin
            if (mul_rsp.done) begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = STEP_W'(35);
               div_cmd.divisor  = {27'd0, k_ff + 5'd1};
               div_cmd.dividend = {mul_rsp.prod[58:24], 61'd0};
               state_in         = S_TDIV;
            end
         end
         S_TDIV: begin
            if (div_rsp.done) begin
               t_in     = div_rsp.quot[34:0];
               k_in     = k_ff + 5'd1;
               state_in = S_TADD;
            end
         end
         S_TFIN: begin
            if (!down_ff) begin
               g_in = psum_ff;
            end else if (psum_ff > nsum_ff) begin
               g_in = psum_ff - nsum_ff;
            end else begin
               g_in = '0;
            end
            gcnt_in  = dd_ff[29:24];
            state_in = S_GCHK;
         end
         S_GCHK: begin
            mul_cmd.start = 1'b1;
            if (down_ff && gcnt_ff != 6'd0 && g_ff != '0) begin
               mul_cmd.a = {28'd0, g_ff};
               mul_cmd.b = {31'd0, EXP_NEG1};
               state_in  = S_GMUL;
            end else begin
               mul_cmd.a = {16'd0, mag_ff};
               mul_cmd.b = {40'd0, cur_scale};
               state_in  = S_AMUL;
            end
         end
         S_GMUL: begin
            if (mul_rsp.done) begin
               g_in     = {3'd0, mul_rsp.prod[64:32]};
               gcnt_in  = gcnt_ff - 6'd1;
               state_in = S_GCHK;
            end
         end
         S_AMUL: begin
            if (mul_rsp.done) begin
               a_in          = mul_rsp.prod[70:16];
               mul_cmd.start = 1'b1;
               mul_cmd.a     = {34'd0, r_ff};
               mul_cmd.b     = {28'd0, g_ff};
               state_in      = S_CMUL;
            end
         end
         S_CMUL: begin
            if (mul_rsp.done) begin
               c_in          = mul_rsp.prod[64:25];
               mul_cmd.start = 1'b1;
               mul_cmd.a     = {9'd0, a_ff};
               mul_cmd.b     = {24'd0, mul_rsp.prod[64:25]};
               state_in      = S_PMUL;
            end
         end
         S_PMUL: begin
            if (mul_rsp.done) begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = STEP_W'(96);
               div_cmd.divisor  = {peak_ff, 1'b0};
               div_cmd.dividend = mul_rsp.prod[95:0];
               state_in         = S_FDIV;
            end
         end
         S_FDIV: begin
            if (div_rsp.done) begin
               sum_in   = sum_wide[63] ? COUNT_MAX : sum_wide[62:0];
               ent_in   = ent_ff + CNT_W'(1);
               state_in = S_NEXT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = sum_ff;
         rsp_status_in = status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ion_cnt_ff   <= '0;
         mag_cnt_ff   <= '0;
         ion_bnd_ff   <= '0;
         mag_bnd_ff   <= '0;
         ion_scl_ff   <= 24'd65536;
         mag_scl_ff   <= 24'd65536;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ion_cnt_ff   <= ion_cnt_in;
         mag_cnt_ff   <= mag_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ION_BOUNDARY: ion_bnd_ff <= csr_wdata;
               CSR_MAG_BOUNDARY: mag_bnd_ff <= csr_wdata;
               CSR_ION_SCALE:    ion_scl_ff <= csr_wdata[23:0];
               CSR_MAG_SCALE:    mag_scl_ff <= csr_wdata[23:0];
               default:          ion_bnd_ff <= ion_bnd_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tbl_ff        <= tbl_in;
      ent_ff        <= ent_in;
      ion_on_ff     <= ion_on_in;
      mag_on_ff     <= mag_on_in;
      energy_ff     <= energy_in;
      pk_ff         <= pk_in;
      peak_ff       <= peak_in;
      mag_ff        <= mag_in;
      r_ff          <= r_in;
      down_ff       <= down_in;
      dd_ff         <= dd_in;
      t_ff          <= t_in;
      psum_ff       <= psum_in;
      nsum_ff       <= nsum_in;
      k_ff          <= k_in;
      g_ff          <= g_in;
      gcnt_ff       <= gcnt_in;
      a_ff          <= a_in;
      c_ff          <= c_in;
      sum_ff        <= sum_in;
      status_ff     <= status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ rtl/msfs_checker.sv @@
// Port-level checker for the Maxwellian source flux sum unit, bound to the top level.
// Depends on assert_macros.svh and the top level's port list.
`include "assert_macros.svh"

module msfs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_type,
   input logic [31:0]        req_energy,
   input logic [31:0]        req_position,
   input logic signed [31:0] req_peak_energy,
   input logic signed [47:0] req_magnitude,
   input logic signed [15:0] req_parts_at_energy,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [62:0]        rsp_count,
   input logic [2:0]         rsp_status,
   input logic               csr_wr_en,
   input logic [1:0]         csr_index,
   input logic [31:0]        csr_wdata
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_count) && $stable(rsp_status), "response changed while stalled")

   `ASSERT_SAME(a_status_range, clock, reset, rsp_valid,
      rsp_status <= 3'd4, "response status out of range")

   `ASSERT_SAME(a_load_no_count, clock, reset, rsp_valid && rsp_status != 3'd0,
      rsp_count == 63'd0, "failed load carries a count")

   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready,
      !req_ready, "request taken while the previous one is in work")

endmodule

bind maxwellian_source_flux_sum_unit msfs_checker u_msfs_checker (.*);
